/* rtl/epg_pkg.sv */
`default_nettype none

package epg_pkg;

    localparam int RADIUS_BITS_DFLT = 10;
    localparam int COORD_BITS_DFLT  = 12;

    // decision register and the exact start-value accumulator
    localparam int DEC_BITS = 48;
    localparam int ACC_BITS = 64;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    typedef enum logic [1:0] {
        ACC_HOLD = 2'd0,
        ACC_LOAD = 2'd1,
        ACC_ADD  = 2'd2,
        ACC_BASE = 2'd3
    } acc_op_t;

    // control word for the shared multiply-accumulate unit
    typedef struct packed {
        acc_op_t op;
        logic    neg;
        logic    quad;
    } mac_ctrl_t;

endpackage

`default_nettype wire

/* rtl/epg_mac.sv */
`default_nettype none

module epg_mac #(
    parameter int MUL_A_BITS = 2 * epg_pkg::RADIUS_BITS_DFLT,
    parameter int MUL_B_BITS = 2 * epg_pkg::RADIUS_BITS_DFLT + 4
) (
    input  wire logic                                 clk,
    input  wire epg_pkg::mac_ctrl_t                   ctrl,
    input  wire logic [MUL_A_BITS-1:0]                mul_a,
    input  wire logic [MUL_B_BITS-1:0]                mul_b,
    input  wire logic [epg_pkg::ACC_BITS-1:0]         base,
    output logic      [MUL_A_BITS+MUL_B_BITS-1:0]     prod,
    output logic      [epg_pkg::ACC_BITS-1:0]         acc,
    output logic      [epg_pkg::ACC_BITS-1:0]         sum
);
    import epg_pkg::*;

    localparam int PROD_BITS = MUL_A_BITS + MUL_B_BITS;

    logic [PROD_BITS-1:0] prod_reg;
    logic [ACC_BITS-1:0]  acc_reg;
    logic [ACC_BITS-1:0]  addend_mag;
    logic [ACC_BITS-1:0]  addend;

    // product is registered and taken in the cycle after issue; arithmetic is modulo 2^ACC_BITS
    always_comb
    begin
        addend_mag = ACC_BITS'(prod_reg);
        if (ctrl.quad)
        begin
            addend_mag = addend_mag << 2;
        end
        addend = ctrl.neg ? (~addend_mag + ACC_BITS'(1)) : addend_mag;
        case (ctrl.op)
            ACC_LOAD: sum = addend;
            ACC_ADD:  sum = acc_reg + addend;
            ACC_BASE: sum = base + addend;
            default:  sum = acc_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        acc_reg  <= sum;
    end

    assign prod = prod_reg;
    assign acc  = acc_reg;

endmodule

`default_nettype wire

/* rtl/ellipse_point_generator.sv */
// Midpoint ellipse rasterizer, one quartet of symmetric points per step item.
// Input channel (in_valid/in_stall): command 0 loads radii and center and
// produces nothing; command 1 produces the next quartet, or nothing once the
// ellipse is finished. Output channel (out_valid/out_stall) carries the four
// points and last_quartet, set on the final quartet at y = 0.
// One item is worked at a time by a sequencer around a single registered
// multiplier and a 64-bit accumulator; in_stall is high while it runs.
// A start runs S_SQX to S_QUART; a region-1 step runs S_R1_TX to S_R1_UPD2;
// a region-2 step runs S_R2_EMIT to S_R2_UPD2. The step crossing into region
// 2 runs S_R1_TX to S_R1_CMP, S_R2S_1 to S_R2S_5 (five products for its start
// value), S_QUART and the region-2 states. The quartet is registered as an
// emit state is left. A step with no ellipse in progress is taken in S_IDLE.
// The result sits in an output register; a new item is taken while it waits.
// If the receiver stalls, the next quartet is held back until the register
// frees up, and the sequencer waits in its emit cycle.
// Reset clears the sequencer, the region and out_valid; a step before any
// start produces nothing.
`default_nettype none

module ellipse_point_generator #(
    parameter int RADIUS_BITS = epg_pkg::RADIUS_BITS_DFLT,
    parameter int COORD_BITS  = epg_pkg::COORD_BITS_DFLT
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic                         command,
    input  wire logic [RADIUS_BITS-1:0]       radius_x,
    input  wire logic [RADIUS_BITS-1:0]       radius_y,
    input  wire logic [RADIUS_BITS-1:0]       center_x,
    input  wire logic [RADIUS_BITS-1:0]       center_y,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic signed [COORD_BITS-1:0]      pt0_x,
    output logic signed [COORD_BITS-1:0]      pt0_y,
    output logic signed [COORD_BITS-1:0]      pt1_x,
    output logic signed [COORD_BITS-1:0]      pt1_y,
    output logic signed [COORD_BITS-1:0]      pt2_x,
    output logic signed [COORD_BITS-1:0]      pt2_y,
    output logic signed [COORD_BITS-1:0]      pt3_x,
    output logic signed [COORD_BITS-1:0]      pt3_y,
    output logic                              last_quartet
);
    import epg_pkg::*;

    localparam int X_BITS    = RADIUS_BITS + 1;
    localparam int Y_BITS    = RADIUS_BITS + 2;
    localparam int SQ_BITS   = 2 * RADIUS_BITS;
    localparam int MA_BITS   = 2 * RADIUS_BITS;
    localparam int MB_BITS   = 2 * RADIUS_BITS + 4;
    localparam int PROD_BITS = MA_BITS + MB_BITS;

    typedef enum logic [19:0] {
        S_IDLE    = 20'h00001,
        S_SQX     = 20'h00002,
        S_SQY     = 20'h00004,
        S_CROSS   = 20'h00008,
        S_FIN     = 20'h00010,
        S_QUART   = 20'h00020,
        S_R1_TX   = 20'h00040,
        S_R1_TY   = 20'h00080,
        S_R1_CMP  = 20'h00100,
        S_R1_EMIT = 20'h00200,
        S_R1_UPD1 = 20'h00400,
        S_R1_UPD2 = 20'h00800,
        S_R2S_1   = 20'h01000,
        S_R2S_2   = 20'h02000,
        S_R2S_3   = 20'h04000,
        S_R2S_4   = 20'h08000,
        S_R2S_5   = 20'h10000,
        S_R2_EMIT = 20'h20000,
        S_R2_UPD1 = 20'h40000,
        S_R2_UPD2 = 20'h80000
    } seq_state_t;

    typedef enum logic [2:0] {
        P_IDLE = 3'b001,
        P_R1   = 3'b010,
        P_R2   = 3'b100
    } phase_t;

    seq_state_t state_reg, state_next;
    phase_t     phase_reg, phase_next;
    logic       out_valid_reg, out_valid_next;

    logic [X_BITS-1:0]          walk_x_reg, walk_x_next;
    logic signed [Y_BITS-1:0]   walk_y_reg, walk_y_next;
    logic [DEC_BITS-1:0]        dec_reg, dec_next;
    logic [SQ_BITS-1:0]         rx_sq_reg, rx_sq_next;
    logic [SQ_BITS-1:0]         ry_sq_reg, ry_sq_next;
    logic [RADIUS_BITS-1:0]     rx_reg, rx_next;
    logic [RADIUS_BITS-1:0]     cx_reg, cx_next;
    logic [RADIUS_BITS-1:0]     cy_reg, cy_next;

    logic [COORD_BITS-1:0]      xp_reg, xm_reg, yp_reg, ym_reg;
    logic                       last_reg;
    logic [COORD_BITS-1:0]      xp, xm, yp, ym, y_c;

    mac_ctrl_t                  ctrl;
    logic [MA_BITS-1:0]         mul_a;
    logic [MB_BITS-1:0]         mul_b;
    logic [ACC_BITS-1:0]        dec_ext;
    logic [PROD_BITS-1:0]       mac_prod;
    logic [ACC_BITS-1:0]        mac_acc, mac_sum;
    logic [ACC_BITS-1:0]        acc_round;

    logic                       slot_free, emit, emit_last, in_region1;
    logic                       y_pos, y_zero, y_ge2, dec_neg;
    logic [X_BITS+1:0]          x2p3, x2p2;
    logic [X_BITS:0]            a_odd;
    logic [Y_BITS:0]            y2, y2m2, y_odd_abs;
    logic [Y_BITS-1:0]          b_abs;

    // walk-derived operands
    assign y_zero  = (walk_y_reg == '0);
    assign y_pos   = !walk_y_reg[Y_BITS-1] && !y_zero;
    assign y_ge2   = !walk_y_reg[Y_BITS-1] && (|walk_y_reg[Y_BITS-2:1]);
    assign dec_neg = dec_reg[DEC_BITS-1];
    assign x2p3    = {1'b0, walk_x_reg, 1'b0} + (X_BITS+2)'(3);
    assign x2p2    = {1'b0, walk_x_reg, 1'b0} + (X_BITS+2)'(2);
    assign a_odd   = {walk_x_reg, 1'b1};
    assign y2      = {walk_y_reg, 1'b0};
    assign y2m2    = y2 - (Y_BITS+1)'(2);
    assign y_odd_abs = y_ge2 ? (y2 - (Y_BITS+1)'(3)) : ((Y_BITS+1)'(3) - y2);
    // |y - 1|, y is never negative when this is used
    assign b_abs   = y_zero ? Y_BITS'(1) : ($unsigned(walk_y_reg) - Y_BITS'(1));

    assign dec_ext = {{(ACC_BITS-DEC_BITS){dec_reg[DEC_BITS-1]}}, dec_reg};
    assign in_region1 = y_pos && (ACC_BITS'(mac_prod) > mac_acc);
    // divide by four, truncating toward zero
    assign acc_round = mac_acc + (mac_acc[ACC_BITS-1] ? ACC_BITS'(3) : '0);

    assign y_c = COORD_BITS'(walk_y_reg);
    assign xp  = COORD_BITS'(cx_reg) + COORD_BITS'(walk_x_reg);
    assign xm  = COORD_BITS'(cx_reg) - COORD_BITS'(walk_x_reg);
    assign yp  = COORD_BITS'(cy_reg) + y_c;
    assign ym  = COORD_BITS'(cy_reg) - y_c;

    assign slot_free = !out_valid_reg || !out_stall;

    epg_mac #(
        .MUL_A_BITS (MA_BITS),
        .MUL_B_BITS (MB_BITS)
    ) u_mac (
        .clk   (clk),
        .ctrl  (ctrl),
        .mul_a (mul_a),
        .mul_b (mul_b),
        .base  (dec_ext),
        .prod  (mac_prod),
        .acc   (mac_acc),
        .sum   (mac_sum)
    );

    always_comb
    begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        walk_x_next = walk_x_reg;
        walk_y_next = walk_y_reg;
        dec_next    = dec_reg;
        rx_sq_next  = rx_sq_reg;
        ry_sq_next  = ry_sq_reg;
        rx_next     = rx_reg;
        cx_next     = cx_reg;
        cy_next     = cy_reg;
        ctrl        = '{op: ACC_HOLD, neg: 1'b0, quad: 1'b0};
        mul_a       = '0;
        mul_b       = '0;
        emit        = 1'b0;
        emit_last   = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (command == CMD_START)
                    begin
                        rx_next     = radius_x;
                        walk_y_next = Y_BITS'(radius_y);
                        walk_x_next = '0;
                        cx_next     = center_x;
                        cy_next     = center_y;
                        phase_next  = P_R1;
                        state_next  = S_SQX;
                    end
                    else
                    begin
                        case (phase_reg)
                            P_R1:    state_next = S_R1_TX;
                            P_R2:    state_next = S_R2_EMIT;
                            default: state_next = S_IDLE;
                        endcase
                    end
                end
            end

            S_SQX:
            begin
                mul_a      = MA_BITS'(rx_reg);
                mul_b      = MB_BITS'(rx_reg);
                state_next = S_SQY;
            end

            S_SQY:
            begin
                rx_sq_next = mac_prod[SQ_BITS-1:0];
                ctrl.op    = ACC_LOAD;
                mul_a      = MA_BITS'(walk_y_reg[RADIUS_BITS-1:0]);
                mul_b      = MB_BITS'(walk_y_reg[RADIUS_BITS-1:0]);
                state_next = S_CROSS;
            end

            S_CROSS:
            begin
                ry_sq_next = mac_prod[SQ_BITS-1:0];
                ctrl.op    = ACC_ADD;
                ctrl.quad  = 1'b1;
                mul_a      = rx_sq_reg;
                mul_b      = MB_BITS'(walk_y_reg[RADIUS_BITS-1:0]);
                state_next = S_FIN;
            end

            S_FIN:
            begin
                ctrl.op    = ACC_ADD;
                ctrl.neg   = 1'b1;
                ctrl.quad  = 1'b1;
                state_next = S_QUART;
            end

            S_QUART:
            begin
                dec_next   = acc_round[DEC_BITS+1:2];
                state_next = (phase_reg == P_R2) ? S_R2_EMIT : S_IDLE;
            end

            S_R1_TX:
            begin
                mul_a      = ry_sq_reg;
                mul_b      = MB_BITS'(walk_x_reg);
                state_next = S_R1_TY;
            end

            S_R1_TY:
            begin
                ctrl.op    = ACC_LOAD;
                mul_a      = rx_sq_reg;
                mul_b      = MB_BITS'($unsigned(walk_y_reg));
                state_next = S_R1_CMP;
            end

            S_R1_CMP:
            begin
                // (2x+1)^2 is only needed when leaving region 1
                mul_a = MA_BITS'(a_odd);
                mul_b = MB_BITS'(a_odd);
                if (in_region1)
                begin
                    state_next = S_R1_EMIT;
                end
                else
                begin
                    phase_next = P_R2;
                    state_next = S_R2S_1;
                end
            end

            S_R1_EMIT:
            begin
                mul_a = ry_sq_reg;
                mul_b = MB_BITS'(x2p3);
                if (slot_free)
                begin
                    emit       = 1'b1;
                    state_next = S_R1_UPD1;
                end
            end

            S_R1_UPD1:
            begin
                ctrl.op    = ACC_BASE;
                mul_a      = rx_sq_reg;
                mul_b      = MB_BITS'(y2m2);
                state_next = S_R1_UPD2;
            end

            S_R1_UPD2:
            begin
                if (!dec_neg)
                begin
                    ctrl.op     = ACC_ADD;
                    ctrl.neg    = 1'b1;
                    walk_y_next = walk_y_reg - Y_BITS'(1);
                end
                dec_next    = mac_sum[DEC_BITS-1:0];
                walk_x_next = walk_x_reg + X_BITS'(1);
                state_next  = S_IDLE;
            end

            S_R2S_1:
            begin
                mul_a      = ry_sq_reg;
                mul_b      = mac_prod[MB_BITS-1:0];
                state_next = S_R2S_2;
            end

            S_R2S_2:
            begin
                ctrl.op    = ACC_LOAD;
                mul_a      = MA_BITS'(b_abs);
                mul_b      = MB_BITS'(b_abs);
                state_next = S_R2S_3;
            end

            S_R2S_3:
            begin
                mul_a      = rx_sq_reg;
                mul_b      = mac_prod[MB_BITS-1:0];
                state_next = S_R2S_4;
            end

            S_R2S_4:
            begin
                ctrl.op    = ACC_ADD;
                ctrl.quad  = 1'b1;
                mul_a      = rx_sq_reg;
                mul_b      = MB_BITS'(ry_sq_reg);
                state_next = S_R2S_5;
            end

            S_R2S_5:
            begin
                ctrl.op    = ACC_ADD;
                ctrl.neg   = 1'b1;
                ctrl.quad  = 1'b1;
                state_next = S_QUART;
            end

            S_R2_EMIT:
            begin
                mul_a = rx_sq_reg;
                mul_b = MB_BITS'(y_odd_abs);
                if (slot_free)
                begin
                    emit       = 1'b1;
                    emit_last  = y_zero;
                    state_next = S_R2_UPD1;
                end
            end

            S_R2_UPD1:
            begin
                // 3 - 2y goes negative once y reaches 2
                ctrl.op    = ACC_BASE;
                ctrl.neg   = y_ge2;
                mul_a      = ry_sq_reg;
                mul_b      = MB_BITS'(x2p2);
                state_next = S_R2_UPD2;
            end

            S_R2_UPD2:
            begin
                if (dec_neg)
                begin
                    ctrl.op     = ACC_ADD;
                    walk_x_next = walk_x_reg + X_BITS'(1);
                end
                dec_next    = mac_sum[DEC_BITS-1:0];
                walk_y_next = walk_y_reg - Y_BITS'(1);
                if (y_zero)
                begin
                    phase_next = P_IDLE;
                end
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= P_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        walk_x_reg <= walk_x_next;
        walk_y_reg <= walk_y_next;
        dec_reg    <= dec_next;
        rx_sq_reg  <= rx_sq_next;
        ry_sq_reg  <= ry_sq_next;
        rx_reg     <= rx_next;
        cx_reg     <= cx_next;
        cy_reg     <= cy_next;
        if (emit)
        begin
            xp_reg   <= xp;
            xm_reg   <= xm;
            yp_reg   <= yp;
            ym_reg   <= ym;
            last_reg <= emit_last;
        end
    end

    assign in_stall     = (state_reg != S_IDLE);
    assign out_valid    = out_valid_reg;
    assign pt0_x        = xp_reg;
    assign pt0_y        = yp_reg;
    assign pt1_x        = xp_reg;
    assign pt1_y        = ym_reg;
    assign pt2_x        = xm_reg;
    assign pt2_y        = ym_reg;
    assign pt3_x        = xm_reg;
    assign pt3_y        = yp_reg;
    assign last_quartet = last_reg;

endmodule

`default_nettype wire

/* rtl/epg_check.sv */
`default_nettype none

module epg_check #(
    parameter int COORD_BITS = epg_pkg::COORD_BITS_DFLT
) (
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         in_valid,
    input wire logic                         in_stall,
    input wire logic                         command,
    input wire logic                         out_valid,
    input wire logic                         out_stall,
    input wire logic signed [COORD_BITS-1:0] pt0_x,
    input wire logic signed [COORD_BITS-1:0] pt0_y,
    input wire logic signed [COORD_BITS-1:0] pt1_x,
    input wire logic signed [COORD_BITS-1:0] pt1_y,
    input wire logic signed [COORD_BITS-1:0] pt2_x,
    input wire logic signed [COORD_BITS-1:0] pt2_y,
    input wire logic signed [COORD_BITS-1:0] pt3_x,
    input wire logic signed [COORD_BITS-1:0] pt3_y,
    input wire logic                         last_quartet
);
    import epg_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output item dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(pt0_x) && $stable(pt0_y) && $stable(pt2_x)
            && $stable(pt2_y) && $stable(last_quartet))
        else $error("output item changed while stalled");

    // a start always runs the squaring sequence
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && command == CMD_START |=> in_stall)
        else $error("start item did not occupy the block");

    a_symmetry: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pt0_x == pt1_x && pt2_x == pt3_x && pt0_y == pt3_y
            && pt1_y == pt2_y)
        else $error("quartet is not symmetric");

    // the final quartet lies on the horizontal axis
    a_last_axis: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_quartet |-> pt0_y == pt1_y)
        else $error("last quartet off the axis");

endmodule

bind ellipse_point_generator epg_check #(.COORD_BITS(COORD_BITS)) u_epg_check (.*);

`default_nettype wire
